### rtl/core/bthin_pkg.sv
package bthin_pkg;

  // Request codes carried in req_type
  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_RUN   = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  // Register map: index is paddr[2]
  localparam int unsigned PADDR_W  = 3;
  localparam int unsigned PDATA_W  = 32;
  localparam logic        REG_ROWS = 1'b0;
  localparam logic        REG_COLS = 1'b1;
  localparam logic [7:0]  DIM_RESET = 8'd128;

  // Deletion test limits
  localparam logic [3:0] NB_MIN    = 4'd2;
  localparam logic [3:0] NB_MAX    = 4'd6;
  localparam logic [3:0] TRANS_ONE = 4'd1;

  localparam logic [7:0] PASS_MAX = 8'hFF;

  typedef struct packed {
    logic [1:0] req_type;
    logic [6:0] row;
    logic [6:0] col;
    logic       pixel_in;
  } in_item_t;

  typedef struct packed {
    logic       pixel_out;
    logic [7:0] pass_count;
  } out_item_t;

  // Window control from the sequencer to the lane array
  typedef struct packed {
    logic shift;    // take the arriving row into the window
    logic clr_row;  // arriving row is a border row of the scratch copy
    logic second;   // second half-pass rule and border masking
  } win_ctl_t;

  // Ring order: N, NE, E, SE, S, SW, W, NW in bits 0..7
  function automatic logic zs_delete(logic [7:0] nb, logic second);
    logic [3:0] cnt;
    logic [3:0] trans;
    logic       nxt;
    logic       n;
    logic       e;
    logic       s;
    logic       w;
    logic       rule;
    cnt   = '0;
    trans = '0;
    for (int k = 0; k < 8; k++) begin
      nxt = (k == 7) ? nb[0] : nb[k+1];
      cnt = cnt + {3'b000, nb[k]};
      if (!nb[k] && nxt) begin
        trans = trans + 4'd1;
      end
    end
    n = nb[0];
    e = nb[2];
    s = nb[4];
    w = nb[6];
    if (!second) begin
      rule = !(n && e && s) && !(e && s && w);
    end else begin
      rule = !(n && e && w) && !(n && s && w);
    end
    return (cnt >= NB_MIN) && (cnt <= NB_MAX) && (trans == TRANS_ONE) && rule;
  endfunction

endpackage

### rtl/core/bthin_cfg.sv
module bthin_cfg (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [bthin_pkg::PADDR_W-1:0]     paddr,
  input  logic [bthin_pkg::PDATA_W-1:0]     pwdata,
  output logic [bthin_pkg::PDATA_W-1:0]     prdata,
  output logic                              pready,
  output logic [7:0]                        rows_o,
  output logic [7:0]                        cols_o
);
  import bthin_pkg::*;

  logic [7:0] rows_q, rows_d;
  logic [7:0] cols_q, cols_d;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    rows_d = rows_q;
    cols_d = cols_q;
    if (wr_en) begin
      unique case (paddr[2])
        REG_ROWS: rows_d = pwdata[7:0];
        REG_COLS: cols_d = pwdata[7:0];
        default:  rows_d = rows_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_ROWS: prdata = {24'd0, rows_q};
      REG_COLS: prdata = {24'd0, cols_q};
      default:  prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= DIM_RESET;
      cols_q <= DIM_RESET;
    end else begin
      rows_q <= rows_d;
      cols_q <= cols_d;
    end
  end

  assign rows_o = rows_q;
  assign cols_o = cols_q;

endmodule

### rtl/core/bthin_lanes.sv
module bthin_lanes #(
  parameter int unsigned MAX_COLS = 128
) (
  input  logic                     clk_i,
  input  bthin_pkg::win_ctl_t      ctl_i,
  input  logic [MAX_COLS-1:0]      row_i,
  input  logic [MAX_COLS-1:0]      inner_i,
  output logic [MAX_COLS-1:0]      wdata_o,
  output logic                     del_any_o
);
  import bthin_pkg::*;

  // Three-row window: top above center, mid is the center row, bot below
  logic [MAX_COLS-1:0] top_q, mid_q, bot_q;
  logic [MAX_COLS-1:0] row_in;
  logic [MAX_COLS+1:0] tp, mp, bp;
  logic [MAX_COLS-1:0] del;
  logic [7:0]          nb [MAX_COLS];

  // Second half-pass: scratch border reads as background
  always_comb begin
    if (!ctl_i.second) begin
      row_in = row_i;
    end else if (ctl_i.clr_row) begin
      row_in = '0;
    end else begin
      row_in = row_i & inner_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.shift) begin
      top_q <= mid_q;
      mid_q <= bot_q;
      bot_q <= row_in;
    end
  end

  // Pad one background column on each side; bit j+1 holds column j
  assign tp = {1'b0, top_q, 1'b0};
  assign mp = {1'b0, mid_q, 1'b0};
  assign bp = {1'b0, bot_q, 1'b0};

  always_comb begin
    for (int j = 0; j < MAX_COLS; j++) begin
      nb[j]  = {tp[j], mp[j], bp[j], bp[j+1], bp[j+2], mp[j+2], tp[j+2], tp[j+1]};
      del[j] = mid_q[j] && inner_i[j] && zs_delete(nb[j], ctl_i.second);
    end
  end

  assign wdata_o   = mid_q & ~del;
  assign del_any_o = |del;

endmodule

### rtl/core/binary_image_thinning.sv
// Binary image thinning engine. The image lives in a row-wide synchronous
// pixel memory (one row of MAX_COLS pixels per word, per-pixel write enable);
// a second memory of the same shape holds the scratch copy made by the first
// half-pass. Items arrive as transfers on the input channel and each one
// yields exactly one transfer on the output channel. A pixel write (or an
// unknown request) is answered straight from idle; a pixel read waits in a
// read state for the registered read of the pixel memory. A run item walks
// the image one row per cycle through a three-row window and a row of
// deletion lanes, in full passes of two half-passes until nothing changes;
// each half-pass walks the rows through the single read port of its source
// memory. During a run no new item is taken, but image_rows and image_cols
// may only be rewritten while idle. The scratch memory needs
// no clearing after reset: every inner entry is written in the first half of
// a pass before the second half reads it, and its border reads as zero.
// Writes and reads outside the rows and columns in use are dropped and read
// as zero. pass_count reports the full passes of the most recent run,
// saturating at 255, on every result.
module binary_image_thinning #(
  parameter int unsigned MAX_ROWS = 128,
  parameter int unsigned MAX_COLS = 128
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // item input channel
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  bthin_pkg::in_item_t               in_data_i,
  // result output channel
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output bthin_pkg::out_item_t              out_data_o,
  // configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [bthin_pkg::PADDR_W-1:0]     paddr,
  input  logic [bthin_pkg::PDATA_W-1:0]     pwdata,
  output logic [bthin_pkg::PDATA_W-1:0]     prdata,
  output logic                              pready
);
  import bthin_pkg::*;

  localparam int unsigned RW    = $clog2(MAX_ROWS);
  localparam int unsigned CW    = $clog2(MAX_COLS);
  localparam int unsigned MAXD  = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
  localparam int unsigned DIMB  = $clog2(MAXD + 2);
  localparam int unsigned EW    = (DIMB > 8) ? DIMB : 8;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_RUN  = 2'd2;

  // ---------------------------------------------------------------------------
  // Configuration registers and effective dimensions
  // ---------------------------------------------------------------------------
  logic [7:0]    cfg_rows, cfg_cols;
  logic [EW-1:0] eff_rows, eff_cols;

  bthin_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .rows_o  (cfg_rows),
    .cols_o  (cfg_cols)
  );

  // Clamp register values above the built capacity
  assign eff_rows = (EW'(cfg_rows) > EW'(MAX_ROWS)) ? EW'(MAX_ROWS) : EW'(cfg_rows);
  assign eff_cols = (EW'(cfg_cols) > EW'(MAX_COLS)) ? EW'(MAX_COLS) : EW'(cfg_cols);

  // Inner columns: 1 .. cols-2
  logic [MAX_COLS-1:0] inner_mask;
  always_comb begin
    for (int j = 0; j < MAX_COLS; j++) begin
      inner_mask[j] = (j != 0) && (EW'(j + 1) < eff_cols);
    end
  end

  // ---------------------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------------------
  logic [1:0]    state_q, state_d;
  logic [EW-1:0] step_q, step_d;     // row walk position within a half-pass
  logic          half_q, half_d;     // 0: image -> scratch, 1: scratch -> image
  logic          chg_q, chg_d;       // something was deleted in this pass
  logic [7:0]    run_cnt_q, run_cnt_d;
  logic [7:0]    last_pass_q, last_pass_d;
  logic          rd_ok_q, rd_ok_d;
  logic [CW-1:0] rd_col_q, rd_col_d;
  logic          out_valid_q, out_valid_d;
  out_item_t     out_data_q, out_data_d;

  logic          in_fire;
  logic          in_range;
  logic [RW-1:0] in_row;
  logic [CW-1:0] in_col;
  logic          running;
  logic          rd_issue;           // a row read is issued this step
  logic          dvld;               // a row arrives from memory this step
  logic [EW-1:0] drow;
  logic          wr_row;             // a center row is written this step
  logic          last_step;
  logic [7:0]    pass_inc;
  logic          del_any;
  logic          pass_chg;

  assign in_ready_o = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign in_fire    = in_valid_i && in_ready_o;
  assign in_range   = (EW'(in_data_i.row) < eff_rows) && (EW'(in_data_i.col) < eff_cols);
  assign in_row     = RW'(in_data_i.row);
  assign in_col     = CW'(in_data_i.col);

  // Read row s at step s; its data arrives at step s+1. The window holds
  // row s-2 at the bottom at step s, so center row s-3 is decided then.
  assign running   = (state_q == ST_RUN);
  assign rd_issue  = running && (step_q < eff_rows);
  assign dvld      = running && (step_q != '0) && (step_q <= eff_rows);
  assign drow      = step_q - EW'(1);
  assign wr_row    = running && (step_q >= EW'(4)) && (step_q <= eff_rows + EW'(1));
  assign last_step = (step_q == eff_rows + EW'(1));
  assign pass_inc  = (run_cnt_q == PASS_MAX) ? PASS_MAX : run_cnt_q + 8'd1;
  assign pass_chg  = chg_q || (wr_row && del_any);

  // ---------------------------------------------------------------------------
  // Memories: row-wide words, per-pixel write enable, registered read
  // ---------------------------------------------------------------------------
  logic [MAX_COLS-1:0] pix_mem [MAX_ROWS];
  logic [MAX_COLS-1:0] scr_mem [MAX_ROWS];

  logic                pix_re, pix_we, scr_re, scr_we;
  logic [RW-1:0]       pix_raddr, pix_waddr, run_raddr, run_waddr;
  logic [MAX_COLS-1:0] pix_wmask, pix_wdata, pix_rdata_q, scr_rdata_q;
  logic [MAX_COLS-1:0] lane_wdata;

  assign run_raddr = RW'(step_q);
  assign run_waddr = RW'(step_q - EW'(3));

  always_comb begin
    pix_re    = 1'b0;
    pix_raddr = run_raddr;
    pix_we    = 1'b0;
    pix_waddr = run_waddr;
    pix_wmask = inner_mask;
    pix_wdata = lane_wdata;
    if (running) begin
      pix_re = rd_issue && !half_q;
      pix_we = wr_row && half_q;
    end else if (in_fire) begin
      pix_raddr = in_row;
      pix_waddr = in_row;
      pix_re    = (in_data_i.req_type == REQ_READ) && in_range;
      pix_we    = (in_data_i.req_type == REQ_WRITE) && in_range;
      pix_wmask = {{(MAX_COLS-1){1'b0}}, 1'b1} << in_col;
      pix_wdata = {MAX_COLS{in_data_i.pixel_in}};
    end
  end

  assign scr_re = rd_issue && half_q;
  assign scr_we = wr_row && !half_q;

  always_ff @(posedge clk_i) begin
    if (pix_we) begin
      for (int k = 0; k < MAX_COLS; k++) begin
        if (pix_wmask[k]) begin
          pix_mem[pix_waddr][k] <= pix_wdata[k];
        end
      end
    end
    if (pix_re) begin
      pix_rdata_q <= pix_mem[pix_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (scr_we) begin
      for (int k = 0; k < MAX_COLS; k++) begin
        if (inner_mask[k]) begin
          scr_mem[run_waddr][k] <= lane_wdata[k];
        end
      end
    end
    if (scr_re) begin
      scr_rdata_q <= scr_mem[run_raddr];
    end
  end

  // ---------------------------------------------------------------------------
  // Window and deletion lanes
  // ---------------------------------------------------------------------------
  win_ctl_t win_ctl;

  assign win_ctl.shift   = dvld;
  assign win_ctl.clr_row = half_q && ((drow == '0) || (drow == eff_rows - EW'(1)));
  assign win_ctl.second  = half_q;

  bthin_lanes #(
    .MAX_COLS (MAX_COLS)
  ) u_lanes (
    .clk_i     (clk_i),
    .ctl_i     (win_ctl),
    .row_i     (half_q ? scr_rdata_q : pix_rdata_q),
    .inner_i   (inner_mask),
    .wdata_o   (lane_wdata),
    .del_any_o (del_any)
  );

  // ---------------------------------------------------------------------------
  // Sequencer and result register
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    half_d      = half_q;
    chg_d       = chg_q;
    run_cnt_d   = run_cnt_q;
    last_pass_d = last_pass_q;
    rd_ok_d     = rd_ok_q;
    rd_col_d    = rd_col_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_data_d  = out_data_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_data_i.req_type)
            REQ_RUN: begin
              state_d   = ST_RUN;
              step_d    = '0;
              half_d    = 1'b0;
              chg_d     = 1'b0;
              run_cnt_d = '0;
            end
            REQ_READ: begin
              // hold until the row arrives from memory
              state_d  = ST_READ;
              rd_ok_d  = in_range;
              rd_col_d = in_col;
            end
            default: begin
              // write, or unknown request: answer at once
              out_valid_d           = 1'b1;
              out_data_d.pixel_out  = 1'b0;
              out_data_d.pass_count = last_pass_q;
            end
          endcase
        end
      end
      ST_READ: begin
        state_d               = ST_IDLE;
        out_valid_d           = 1'b1;
        out_data_d.pixel_out  = rd_ok_q && pix_rdata_q[rd_col_q];
        out_data_d.pass_count = last_pass_q;
      end
      ST_RUN: begin
        step_d = step_q + EW'(1);
        chg_d  = pass_chg;
        if (last_step) begin
          step_d = '0;
          if (!half_q) begin
            half_d = 1'b1;
          end else begin
            half_d    = 1'b0;
            chg_d     = 1'b0;
            run_cnt_d = pass_inc;
            if (!pass_chg) begin
              // converged: report and drop back to idle
              state_d               = ST_IDLE;
              last_pass_d           = pass_inc;
              out_valid_d           = 1'b1;
              out_data_d.pixel_out  = 1'b0;
              out_data_d.pass_count = pass_inc;
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      half_q      <= 1'b0;
      chg_q       <= 1'b0;
      run_cnt_q   <= '0;
      last_pass_q <= '0;
      rd_ok_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      half_q      <= half_d;
      chg_q       <= chg_d;
      run_cnt_q   <= run_cnt_d;
      last_pass_q <= last_pass_d;
      rd_ok_q     <= rd_ok_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_col_q   <= rd_col_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

### tb/thinning_checker.sv
module thinning_checker #(
  parameter int unsigned MAX_ROWS = 128,
  parameter int unsigned MAX_COLS = 128
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  input  logic                                in_ready_i,
  input  bthin_pkg::in_item_t                 in_data_i,
  input  logic                                out_valid_i,
  input  logic                                out_ready_i,
  input  bthin_pkg::out_item_t                out_data_i,
  input  logic                                psel_i,
  input  logic                                penable_i,
  input  logic                                pwrite_i,
  input  logic [bthin_pkg::PADDR_W-1:0]       paddr_i,
  input  logic [bthin_pkg::PDATA_W-1:0]       pwdata_i,
  input  logic [bthin_pkg::PDATA_W-1:0]       prdata_i,
  input  logic                                pready_i,
  output int                                  mismatch_cnt_o,
  output int                                  results_due_o
);

  import bthin_pkg::*;

  localparam int unsigned PIXELS    = MAX_ROWS * MAX_COLS;
  localparam int          PRINT_MAX = 50;

  // Shadow copy of the block's state
  bit         pix_img [PIXELS];
  bit         scr_img [PIXELS];
  logic [7:0] dim_rows;
  logic [7:0] dim_cols;
  logic [7:0] last_passes;

  out_item_t  pending_results [$];
  out_item_t  want;
  out_item_t  predicted;
  logic [7:0] want_dim;
  int         mismatches;

  assign mismatch_cnt_o = mismatches;

  task automatic report_mismatch(string msg);
    if (mismatches < PRINT_MAX) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
    mismatches++;
  endtask

  function automatic int rows_in_use();
    return (dim_rows > MAX_ROWS) ? MAX_ROWS : int'(dim_rows);
  endfunction

  function automatic int cols_in_use();
    return (dim_cols > MAX_COLS) ? MAX_COLS : int'(dim_cols);
  endfunction

  // The scratch copy reads as background on its border
  function automatic bit px_at(bit from_scr, int rows, int cols, int i, int j);
    if (i >= rows || j >= cols) return 1'b0;
    if (!from_scr) return pix_img[i*MAX_COLS + j];
    if (i == 0 || j == 0 || i == rows - 1 || j == cols - 1) return 1'b0;
    return scr_img[i*MAX_COLS + j];
  endfunction

  // Second half-pass looks at the scratch copy and uses its own rule
  function automatic bit erasable(bit second, int rows, int cols, int i, int j);
    bit [7:0] ring;
    int       fg;
    int       rises;
    bit       n;
    bit       e;
    bit       s;
    bit       w;
    ring[0] = px_at(second, rows, cols, i - 1, j);
    ring[1] = px_at(second, rows, cols, i - 1, j + 1);
    ring[2] = px_at(second, rows, cols, i, j + 1);
    ring[3] = px_at(second, rows, cols, i + 1, j + 1);
    ring[4] = px_at(second, rows, cols, i + 1, j);
    ring[5] = px_at(second, rows, cols, i + 1, j - 1);
    ring[6] = px_at(second, rows, cols, i, j - 1);
    ring[7] = px_at(second, rows, cols, i - 1, j - 1);
    fg    = 0;
    rises = 0;
    for (int k = 0; k < 8; k++) begin
      fg += ring[k];
      if (!ring[k] && ring[(k + 1) % 8]) rises++;
    end
    if (fg < NB_MIN || fg > NB_MAX || rises != TRANS_ONE) return 1'b0;
    n = ring[0];
    e = ring[2];
    s = ring[4];
    w = ring[6];
    if (!second) return !(n && e && s) && !(e && s && w);
    return !(n && e && w) && !(n && s && w);
  endfunction

  // Full passes until one deletes nothing; returns the saturated pass count
  function automatic logic [7:0] thin_image();
    int rows;
    int cols;
    int passes;
    int a;
    bit changed;
    rows   = rows_in_use();
    cols   = cols_in_use();
    passes = 0;
    do begin
      changed = 1'b0;
      passes++;
      if (rows >= 3 && cols >= 3) begin
        for (int i = 1; i + 1 < rows; i++) begin
          for (int j = 1; j + 1 < cols; j++) begin
            a = i*MAX_COLS + j;
            scr_img[a] = pix_img[a];
            if (pix_img[a] && erasable(1'b0, rows, cols, i, j)) begin
              scr_img[a] = 1'b0;
              changed    = 1'b1;
            end
          end
        end
        for (int i = 1; i + 1 < rows; i++) begin
          for (int j = 1; j + 1 < cols; j++) begin
            a = i*MAX_COLS + j;
            pix_img[a] = scr_img[a];
            if (scr_img[a] && erasable(1'b1, rows, cols, i, j)) begin
              pix_img[a] = 1'b0;
              changed    = 1'b1;
            end
          end
        end
      end
    end while (changed);
    return (passes > 255) ? PASS_MAX : 8'(passes);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < PIXELS; a++) begin
        pix_img[a] = 1'b0;
        scr_img[a] = 1'b0;
      end
      dim_rows    = DIM_RESET;
      dim_cols    = DIM_RESET;
      last_passes = '0;
      pending_results.delete();
      results_due_o <= 0;
    end else begin
      // Register port: track writes, check reads
      if (psel_i && penable_i && pready_i) begin
        if (pwrite_i) begin
          if (paddr_i[2] == REG_COLS) dim_cols = pwdata_i[7:0];
          else dim_rows = pwdata_i[7:0];
        end else begin
          want_dim = (paddr_i[2] == REG_COLS) ? dim_cols : dim_rows;
          if (prdata_i[7:0] !== want_dim) begin
            report_mismatch($sformatf("register read at %0d: got %0d expected %0d",
                                      paddr_i, prdata_i[7:0], want_dim));
          end
        end
      end

      // Result transfer: compare with the oldest prediction
      if (out_valid_i && out_ready_i) begin
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("result with no item waiting: pixel_out %0b pass_count %0d",
                                    out_data_i.pixel_out, out_data_i.pass_count));
        end else begin
          want = pending_results.pop_front();
          if (out_data_i.pixel_out !== want.pixel_out) begin
            report_mismatch($sformatf("pixel_out got %0b expected %0b",
                                      out_data_i.pixel_out, want.pixel_out));
          end
          if (out_data_i.pass_count !== want.pass_count) begin
            report_mismatch($sformatf("pass_count got %0d expected %0d",
                                      out_data_i.pass_count, want.pass_count));
          end
        end
      end

      // Item transfer: apply it to the shadow state and predict its result
      if (in_valid_i && in_ready_i) begin
        predicted.pixel_out = 1'b0;
        case (in_data_i.req_type)
          REQ_WRITE: begin
            if (int'(in_data_i.row) < rows_in_use() && int'(in_data_i.col) < cols_in_use()) begin
              pix_img[int'(in_data_i.row)*MAX_COLS + int'(in_data_i.col)] = in_data_i.pixel_in;
            end
          end
          REQ_RUN: begin
            last_passes = thin_image();
          end
          REQ_READ: begin
            if (int'(in_data_i.row) < rows_in_use() && int'(in_data_i.col) < cols_in_use()) begin
              predicted.pixel_out = pix_img[int'(in_data_i.row)*MAX_COLS + int'(in_data_i.col)];
            end
          end
          default: ;
        endcase
        predicted.pass_count = last_passes;
        pending_results.push_back(predicted);
      end

      results_due_o <= pending_results.size();
    end
  end

endmodule

### tb/binary_image_thinning_tb.sv
module binary_image_thinning_tb;

  import bthin_pkg::*;

  localparam int unsigned MAX_ROWS = 128;
  localparam int unsigned MAX_COLS = 128;
  localparam int unsigned PIXELS   = MAX_ROWS * MAX_COLS;

  // Request code outside the defined set; the block answers it without touching the image
  localparam logic [1:0] REQ_NONE = 2'd3;

  localparam logic [PADDR_W-1:0] ADDR_ROWS = {REG_ROWS, 2'b00};
  localparam logic [PADDR_W-1:0] ADDR_COLS = {REG_COLS, 2'b00};

  localparam int IDLE_PCT      = 16;
  localparam int HOLD_CYCLES   = 400;
  localparam int DRAIN_CYCLES  = 16;
  localparam int TIMEOUT_UNITS = 4_000_000;

  logic                clk;
  logic                rst_n    = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  in_item_t            in_data  = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_item_t           out_data;
  logic                psel    = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite  = 1'b0;
  logic [PADDR_W-1:0]  paddr   = '0;
  logic [PDATA_W-1:0]  pwdata  = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  int                  mismatches;
  int                  results_due;

  // Stimulus-side bookkeeping
  bit                  gaps_on   = 1'b1;
  int                  hold_reqs = 0;
  int                  cur_rows  = MAX_ROWS;
  int                  cur_cols  = MAX_COLS;
  bit                  px_written [PIXELS];

  binary_image_thinning #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  thinning_checker #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS)
  ) checker_i (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .in_data_i     (in_data),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .out_data_i    (out_data),
    .psel_i        (psel),
    .penable_i     (penable),
    .pwrite_i      (pwrite),
    .paddr_i       (paddr),
    .pwdata_i      (pwdata),
    .prdata_i      (prdata),
    .pready_i      (pready),
    .mismatch_cnt_o(mismatches),
    .results_due_o (results_due)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Hard stop in case a transfer never completes
  initial begin : watchdog
    #(TIMEOUT_UNITS);
    $display("Simulation FAILED");
    $finish;
  end

  // Result sink: stall at random, and on request hold off for a long
  // stretch so the block backs up and stalls its input channel.
  initial begin : result_sink
    int holds_served;
    int stall_left;
    holds_served = 0;
    forever begin
      @(posedge clk);
      if (hold_reqs != holds_served) begin
        holds_served++;
        out_ready <= 1'b0;
        for (stall_left = HOLD_CYCLES; stall_left > 0; stall_left--) begin
          @(posedge clk);
        end
      end
      out_ready <= !gaps_on || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  function automatic bit in_use(int r, int c);
    return (r < cur_rows) && (c < cur_cols);
  endfunction

  // Offer one item and hold it until the transfer happens. Valid stays
  // high on return so back-to-back items need no extra step; callers that
  // stop sending drop it through wait_drained.
  task automatic offer_item(logic [1:0] kind, int r, int c, bit px);
    in_item_t item;
    item.req_type = kind;
    item.row      = 7'(r);
    item.col      = 7'(c);
    item.pixel_in = px;
    while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (kind == REQ_WRITE && in_use(r, c)) px_written[r*MAX_COLS + c] = 1'b1;
  endtask

  // Drop valid and wait until every predicted result has been transferred
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
  endtask

  // One register transfer: setup cycle, then access cycle; leave with psel low
  task automatic reg_access(bit wr, logic [PADDR_W-1:0] addr, logic [7:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= PDATA_W'(val);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Reprogram the image size while idle and read both registers back
  task automatic set_dims(int rows_val, int cols_val);
    wait_drained();
    reg_access(1'b1, ADDR_ROWS, 8'(rows_val));
    reg_access(1'b1, ADDR_COLS, 8'(cols_val));
    reg_access(1'b0, ADDR_ROWS, 8'd0);
    reg_access(1'b0, ADDR_COLS, 8'd0);
    cur_rows = (rows_val > MAX_ROWS) ? MAX_ROWS : rows_val;
    cur_cols = (cols_val > MAX_COLS) ? MAX_COLS : cols_val;
  endtask

  // Load a 3x3 image from a mask, bit 3*row+col
  task automatic load_block(bit [8:0] mask);
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        offer_item(REQ_WRITE, i, j, mask[i*3 + j]);
      end
    end
  endtask

  // Write every pixel in use: a random rectangle of foreground on
  // background, with a random amount of speckle in both
  task automatic fill_region();
    int r0;
    int r1;
    int c0;
    int c1;
    int noise;
    bit in_rect;
    bit px;
    r0    = $urandom_range(cur_rows - 1);
    r1    = $urandom_range(cur_rows - 1, r0);
    c0    = $urandom_range(cur_cols - 1);
    c1    = $urandom_range(cur_cols - 1, c0);
    noise = ($urandom_range(2) == 0) ? 0 : $urandom_range(25);
    for (int i = 0; i < cur_rows; i++) begin
      for (int j = 0; j < cur_cols; j++) begin
        in_rect = (i >= r0) && (i <= r1) && (j >= c0) && (j <= c1);
        px      = in_rect ? ($urandom_range(99) >= noise) : ($urandom_range(99) < noise);
        offer_item(REQ_WRITE, i, j, px);
      end
    end
  endtask

  // Mixed traffic over a fully loaded image; a quarter of the accesses
  // land anywhere in the field range, most of them out of range
  task automatic random_items(int count);
    int  roll;
    int  r;
    int  c;
    bit  anywhere;
    for (int k = 0; k < count; k++) begin
      roll     = $urandom_range(99);
      anywhere = ($urandom_range(99) < 25);
      r        = anywhere ? $urandom_range(127) : $urandom_range(cur_rows - 1);
      c        = anywhere ? $urandom_range(127) : $urandom_range(cur_cols - 1);
      if (roll < 50) begin
        offer_item(REQ_WRITE, r, c, $urandom_range(1));
      end else if (roll < 86) begin
        // never read a pixel that holds nothing yet
        if (in_use(r, c) && !px_written[r*MAX_COLS + c]) begin
          offer_item(REQ_WRITE, r, c, $urandom_range(1));
        end else begin
          offer_item(REQ_READ, r, c, $urandom_range(1));
        end
      end else if (roll < 93) begin
        offer_item(REQ_RUN, r, c, $urandom_range(1));
      end else begin
        offer_item(REQ_NONE, r, c, $urandom_range(1));
      end
    end
  endtask

  // Size the image, load it, thin it, then mixed traffic and a final run
  task automatic run_phase(int rows_val, int cols_val, int count, bit stall_sink);
    set_dims(rows_val, cols_val);
    if (stall_sink) hold_reqs <= hold_reqs + 1;
    fill_region();
    offer_item(REQ_RUN, $urandom_range(127), $urandom_range(127), $urandom_range(1));
    random_items(count);
    offer_item(REQ_RUN, $urandom_range(127), $urandom_range(127), $urandom_range(1));
  endtask

  initial begin : stimulus
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset size: registers read 128, no run yet so pass_count is zero
    reg_access(1'b0, ADDR_ROWS, 8'd0);
    reg_access(1'b0, ADDR_COLS, 8'd0);
    offer_item(REQ_NONE, 127, 127, 1'b1);
    offer_item(REQ_WRITE, 0, 0, 1'b1);
    offer_item(REQ_WRITE, 127, 127, 1'b1);
    offer_item(REQ_WRITE, 127, 0, 1'b0);
    offer_item(REQ_READ, 0, 0, 1'b0);
    offer_item(REQ_READ, 127, 127, 1'b0);
    offer_item(REQ_READ, 127, 0, 1'b1);

    // Tiny images: no inner pixels, a run reports a single pass.
    // Accesses outside the size in use are dropped and read as zero.
    set_dims(2, 5);
    offer_item(REQ_WRITE, 1, 4, 1'b1);
    offer_item(REQ_WRITE, 2, 0, 1'b1);
    offer_item(REQ_READ, 1, 4, 1'b0);
    offer_item(REQ_READ, 2, 0, 1'b0);
    offer_item(REQ_READ, 1, 5, 1'b0);
    offer_item(REQ_RUN, 0, 0, 1'b0);
    set_dims(0, 128);
    offer_item(REQ_RUN, 127, 127, 1'b1);
    offer_item(REQ_READ, 0, 0, 1'b0);
    set_dims(7, 1);
    offer_item(REQ_RUN, 3, 0, 1'b0);
    offer_item(REQ_NONE, 0, 0, 1'b0);

    // Smallest real image: a full block keeps its center, a 2x2 block at the
    // lower right loses it on the first pass
    set_dims(3, 3);
    load_block(9'h1FF);
    offer_item(REQ_RUN, 0, 0, 1'b0);
    offer_item(REQ_READ, 1, 1, 1'b0);
    load_block(9'b110_110_000);
    offer_item(REQ_RUN, 0, 0, 1'b0);
    offer_item(REQ_READ, 1, 1, 1'b0);

    // Tallest and widest images, sized by register values above the
    // maximum that act as the maximum; hold off the sink during the first
    // load
    run_phase(255, 3, 60, 1'b1);
    run_phase(3, 200, 60, 1'b0);

    // One phase with neither side idling
    gaps_on <= 1'b0;
    run_phase(12, 12, 60, 1'b0);
    gaps_on <= 1'b1;

    repeat (2) begin
      run_phase($urandom_range(12, 3), $urandom_range(12, 3), 40, 1'b0);
    end
    run_phase(3, 3, 20, 1'b0);

    // Drain, then keep watching for any stray result to show up
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && results_due == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/bthin_pkg.sv
rtl/core/bthin_cfg.sv
rtl/core/bthin_lanes.sv
rtl/core/binary_image_thinning.sv
tb/thinning_checker.sv
tb/binary_image_thinning_tb.sv
